>>> src/hsvrgb_pkg.sv
// ----------------------------------------------------------------------------
// hsvrgb_pkg
// Shared types and constants of the HSV to RGB converter: field widths, hue
// sector codes and the reciprocal constants of the division stage.
// ----------------------------------------------------------------------------
package hsvrgb_pkg;

	localparam int HueW   = 9;
	localparam int PctW   = 7;
	localparam int LevelW = 8;

	localparam logic [HueW-1:0] HueFull  = 9'd360;
	localparam logic [HueW-1:0] Hue60    = 9'd60;
	localparam logic [HueW-1:0] Hue120   = 9'd120;
	localparam logic [HueW-1:0] Hue180   = 9'd180;
	localparam logic [HueW-1:0] Hue240   = 9'd240;
	localparam logic [HueW-1:0] Hue300   = 9'd300;
	localparam logic [PctW-1:0] PctFull  = 7'd100;

	// Distance of the hue from the middle of its 120 degree span, 0..60.
	localparam int DistW = 6;
	// 6000 - sat * dist, 0..6000.
	localparam int MidFacW = 13;
	localparam logic [MidFacW-1:0] MidFull = 13'd6000;
	// 255 * val, 0..25500.
	localparam int ScaledW = 15;

	// Numerators of the three levels.
	localparam int HiNumW = 15;   // 255 * v,                max 25500
	localparam int LoNumW = 22;   // 255 * v * (100 - s),    max 2550000
	localparam int MdNumW = 24;   // 17 * v * (6000 - s*d),  max 10200000
	localparam int MdShift = 6;   // 40000 = 64 * 625
	localparam int MdRedW = MdNumW - MdShift;

	// Reciprocals: floor(x / D) = (x * M) >> S over the whole numerator range.
	localparam int HiMulW = 15;
	localparam int HiSh   = 21;
	localparam logic [HiMulW-1:0] HiMul = 15'd20972;     // 1 / 100
	localparam int LoMulW = 23;
	localparam int LoSh   = 36;
	localparam logic [LoMulW-1:0] LoMul = 23'd6871948;   // 1 / 10000
	localparam int MdMulW = 21;
	localparam int MdSh   = 30;
	localparam logic [MdMulW-1:0] MdMul = 21'd1717987;   // 1 / 625

	localparam int SecW = 3;
	typedef logic [SecW-1:0] sector_t;
	localparam sector_t SecRed     = 3'd0;   // below 60 degrees
	localparam sector_t SecYellow  = 3'd1;   // below 120
	localparam sector_t SecGreen   = 3'd2;   // below 180
	localparam sector_t SecCyan    = 3'd3;   // below 240
	localparam sector_t SecBlue    = 3'd4;   // below 300
	localparam sector_t SecMagenta = 3'd5;   // up to 360

	typedef struct packed {
		logic [HiNumW-1:0] hi;
		logic [LoNumW-1:0] lo;
		logic [MdNumW-1:0] md;
	} num_t;

	typedef struct packed {
		logic [LevelW-1:0] hi;
		logic [LevelW-1:0] lo;
		logic [LevelW-1:0] md;
	} level_t;

endpackage

>>> src/hsv_to_rgb_converter.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// Converts one HSV colour request to 8-bit red, green and blue levels.
//
// The input channel takes hue_deg, sat_pct and val_pct with in_valid and
// in_stall; the output channel presents red_level, green_level and
// blue_level with out_valid and out_stall. A request moves on a rising edge
// where valid is high and stall is low. Hue is clamped to 360 with 360 read
// as 0; saturation and value are clamped to 100.
// The block is a five-stage pipeline: clamping and sector, the linear
// factors, the numerator products, the reciprocal products and the output
// register. One request is accepted every cycle while in_stall is low; the
// multiplier stages set the depth. When the receiver stalls, the output
// register holds its result and earlier stages keep filling until every
// stage is occupied, after which in_stall is raised. Reset empties every
// stage.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [hsvrgb_pkg::HueW-1:0]         hue_deg,
	input  logic [hsvrgb_pkg::PctW-1:0]         sat_pct,
	input  logic [hsvrgb_pkg::PctW-1:0]         val_pct,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [hsvrgb_pkg::LevelW-1:0]       red_level,
	output logic [hsvrgb_pkg::LevelW-1:0]       green_level,
	output logic [hsvrgb_pkg::LevelW-1:0]       blue_level
);

	logic adv1, adv2, adv3, adv4, adv5;
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;

	// Stage 1 logic.
	logic [hsvrgb_pkg::HueW-1:0]  hue_c;
	logic [hsvrgb_pkg::HueW-1:0]  rem_c;
	logic [hsvrgb_pkg::PctW-1:0]  sat_c;
	logic [hsvrgb_pkg::PctW-1:0]  val_c;
	logic [hsvrgb_pkg::DistW-1:0] dist_c;
	hsvrgb_pkg::sector_t          sec_c;

	hsvrgb_pkg::sector_t          sec_s1, sec_s2, sec_s3, sec_s4;
	logic [hsvrgb_pkg::PctW-1:0]  sat_s1, val_s1, val_s2;
	logic [hsvrgb_pkg::DistW-1:0] dist_s1;

	logic [hsvrgb_pkg::PctW-1:0]    comp_s2;
	logic [hsvrgb_pkg::MidFacW-1:0] midf_s2;
	logic [hsvrgb_pkg::ScaledW-1:0] scaled_s2;
	logic [hsvrgb_pkg::MidFacW-1:0] sat_dist;

	logic [19:0]         vmid;
	hsvrgb_pkg::num_t    num_s3;
	hsvrgb_pkg::level_t  lvl;

	logic [hsvrgb_pkg::LevelW-1:0] red_s5, green_s5, blue_s5;
	logic [hsvrgb_pkg::LevelW-1:0] red_c, green_c, blue_c;

	assign adv5 = !valid_s5 || !out_stall;
	assign adv4 = !valid_s4 || adv5;
	assign adv3 = !valid_s3 || adv4;
	assign adv2 = !valid_s2 || adv3;
	assign adv1 = !valid_s1 || adv2;
	assign in_stall = !adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (adv1) valid_s1 <= in_valid;
			if (adv2) valid_s2 <= valid_s1;
			if (adv3) valid_s3 <= valid_s2;
			if (adv4) valid_s4 <= valid_s3;
			if (adv5) valid_s5 <= valid_s4;
		end
	end

	// Clamping, sector and distance from the middle of the 120 degree span.
	always_comb begin
		hue_c = (hue_deg >= hsvrgb_pkg::HueFull) ? '0 : hue_deg;
		sat_c = (sat_pct > hsvrgb_pkg::PctFull) ? hsvrgb_pkg::PctFull : sat_pct;
		val_c = (val_pct > hsvrgb_pkg::PctFull) ? hsvrgb_pkg::PctFull : val_pct;
		if (hue_c >= hsvrgb_pkg::Hue240) begin
			rem_c = hue_c - hsvrgb_pkg::Hue240;
		end else if (hue_c >= hsvrgb_pkg::Hue120) begin
			rem_c = hue_c - hsvrgb_pkg::Hue120;
		end else begin
			rem_c = hue_c;
		end
		if (rem_c >= hsvrgb_pkg::Hue60) begin
			dist_c = hsvrgb_pkg::DistW'(rem_c - hsvrgb_pkg::Hue60);
		end else begin
			dist_c = hsvrgb_pkg::DistW'(hsvrgb_pkg::Hue60 - rem_c);
		end
		if (hue_c < hsvrgb_pkg::Hue60) begin
			sec_c = hsvrgb_pkg::SecRed;
		end else if (hue_c < hsvrgb_pkg::Hue120) begin
			sec_c = hsvrgb_pkg::SecYellow;
		end else if (hue_c < hsvrgb_pkg::Hue180) begin
			sec_c = hsvrgb_pkg::SecGreen;
		end else if (hue_c < hsvrgb_pkg::Hue240) begin
			sec_c = hsvrgb_pkg::SecCyan;
		end else if (hue_c < hsvrgb_pkg::Hue300) begin
			sec_c = hsvrgb_pkg::SecBlue;
		end else begin
			sec_c = hsvrgb_pkg::SecMagenta;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			sec_s1  <= sec_c;
			sat_s1  <= sat_c;
			val_s1  <= val_c;
			dist_s1 <= dist_c;
		end
	end

	// Linear factors.
	assign sat_dist = hsvrgb_pkg::MidFacW'(sat_s1) * hsvrgb_pkg::MidFacW'(dist_s1);

	always_ff @(posedge clk) begin
		if (adv2) begin
			sec_s2    <= sec_s1;
			val_s2    <= val_s1;
			comp_s2   <= hsvrgb_pkg::PctFull - sat_s1;
			midf_s2   <= hsvrgb_pkg::MidFull - sat_dist;
			scaled_s2 <= (hsvrgb_pkg::ScaledW'(val_s1) << 8) - hsvrgb_pkg::ScaledW'(val_s1);
		end
	end

	// Numerators; 255 / 600000 reduces to 17 / 40000 for the middle level.
	assign vmid = 20'(val_s2) * 20'(midf_s2);

	always_ff @(posedge clk) begin
		if (adv3) begin
			sec_s3    <= sec_s2;
			num_s3.hi <= scaled_s2;
			num_s3.lo <= hsvrgb_pkg::LoNumW'(scaled_s2) * hsvrgb_pkg::LoNumW'(comp_s2);
			num_s3.md <= (hsvrgb_pkg::MdNumW'(vmid) << 4) + hsvrgb_pkg::MdNumW'(vmid);
		end
	end

	hsvrgb_recip u_recip (
		.clk  (clk),
		.load (adv4),
		.num  (num_s3),
		.lvl  (lvl)
	);

	always_ff @(posedge clk) begin
		if (adv4) begin
			sec_s4 <= sec_s3;
		end
	end

	// Placement of the three levels by hue sector.
	always_comb begin
		case (sec_s4)
			hsvrgb_pkg::SecRed: begin
				red_c = lvl.hi; green_c = lvl.md; blue_c = lvl.lo;
			end
			hsvrgb_pkg::SecYellow: begin
				red_c = lvl.md; green_c = lvl.hi; blue_c = lvl.lo;
			end
			hsvrgb_pkg::SecGreen: begin
				red_c = lvl.lo; green_c = lvl.hi; blue_c = lvl.md;
			end
			hsvrgb_pkg::SecCyan: begin
				red_c = lvl.lo; green_c = lvl.md; blue_c = lvl.hi;
			end
			hsvrgb_pkg::SecBlue: begin
				red_c = lvl.md; green_c = lvl.lo; blue_c = lvl.hi;
			end
			default: begin
				red_c = lvl.hi; green_c = lvl.lo; blue_c = lvl.md;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv5) begin
			red_s5   <= red_c;
			green_s5 <= green_c;
			blue_s5  <= blue_c;
		end
	end

	assign out_valid   = valid_s5;
	assign red_level   = red_s5;
	assign green_level = green_s5;
	assign blue_level  = blue_s5;

`ifndef SYNTH
	// The distance from the middle of the span never exceeds sixty degrees.
	a_dist_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (dist_s1 <= 6'd60))
		else $error("hue distance out of range");

	// The minimum level never exceeds the middle level, and neither exceeds the maximum level.
	a_level_order: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s4 |-> (lvl.lo <= lvl.md && lvl.md <= lvl.hi))
		else $error("level ordering broken");

	// The input is only held off while every stage holds a request.
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && valid_s3 && valid_s4 && valid_s5))
		else $error("stall raised with an empty stage");

	// A result held by the receiver is still present in the next cycle, with its red and blue levels unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s5 && out_stall) |=> (valid_s5 && $stable(red_s5) && $stable(blue_s5)))
		else $error("held result lost");
`endif

endmodule

>>> src/hsvrgb_recip.sv
// ----------------------------------------------------------------------------
// hsvrgb_recip
// Division stage: divides the three level numerators by their constant
// denominators through registered reciprocal products.
// ----------------------------------------------------------------------------
module hsvrgb_recip (
	input  logic                clk,
	input  logic                load,
	input  hsvrgb_pkg::num_t    num,
	output hsvrgb_pkg::level_t  lvl
);

	logic [hsvrgb_pkg::HiNumW+hsvrgb_pkg::HiMulW-1:0] hi_prod_s4;
	logic [hsvrgb_pkg::LoNumW+hsvrgb_pkg::LoMulW-1:0] lo_prod_s4;
	logic [hsvrgb_pkg::MdRedW+hsvrgb_pkg::MdMulW-1:0] md_prod_s4;
	logic [hsvrgb_pkg::MdRedW-1:0]                    md_red;

	assign md_red = num.md[hsvrgb_pkg::MdNumW-1:hsvrgb_pkg::MdShift];

	always_ff @(posedge clk) begin
		if (load) begin
			hi_prod_s4 <= (hsvrgb_pkg::HiNumW+hsvrgb_pkg::HiMulW)'(num.hi)
				* (hsvrgb_pkg::HiNumW+hsvrgb_pkg::HiMulW)'(hsvrgb_pkg::HiMul);
			lo_prod_s4 <= (hsvrgb_pkg::LoNumW+hsvrgb_pkg::LoMulW)'(num.lo)
				* (hsvrgb_pkg::LoNumW+hsvrgb_pkg::LoMulW)'(hsvrgb_pkg::LoMul);
			md_prod_s4 <= (hsvrgb_pkg::MdRedW+hsvrgb_pkg::MdMulW)'(md_red)
				* (hsvrgb_pkg::MdRedW+hsvrgb_pkg::MdMulW)'(hsvrgb_pkg::MdMul);
		end
	end

	assign lvl.hi = hi_prod_s4[hsvrgb_pkg::HiSh +: hsvrgb_pkg::LevelW];
	assign lvl.lo = lo_prod_s4[hsvrgb_pkg::LoSh +: hsvrgb_pkg::LevelW];
	assign lvl.md = md_prod_s4[hsvrgb_pkg::MdSh +: hsvrgb_pkg::LevelW];

endmodule

>>> bench/hsv_to_rgb_converter_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_tb
// Self-checking bench for the HSV to RGB converter. A short table of colour
// requests covers the clamping of hue, saturation and value, hue 360 and the
// six sector boundaries. A long random run with bursty requests and a
// receiver that stalls in changing patterns follows. Every accepted request
// is predicted in exact integer arithmetic unless the table pins its result,
// and the results are compared in order, level by level.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_tb;

	localparam int RandomColours = 1700;
	localparam int IdleLimit     = 1000;
	localparam int DrainCycles   = 20;

	typedef struct packed {
		logic [hsvrgb_pkg::LevelW-1:0] red;
		logic [hsvrgb_pkg::LevelW-1:0] green;
		logic [hsvrgb_pkg::LevelW-1:0] blue;
	} rgb_t;

	typedef struct {
		logic [hsvrgb_pkg::HueW-1:0] hue;
		logic [hsvrgb_pkg::PctW-1:0] sat;
		logic [hsvrgb_pkg::PctW-1:0] val;
		bit                          pinned;
		rgb_t                        rgb;
	} colour_row_t;

	logic                          clk         = 1'b0;
	logic                          arst_n      = 1'b0;
	logic                          in_valid    = 1'b0;
	logic                          in_stall;
	logic [hsvrgb_pkg::HueW-1:0]   hue_deg     = '0;
	logic [hsvrgb_pkg::PctW-1:0]   sat_pct     = '0;
	logic [hsvrgb_pkg::PctW-1:0]   val_pct     = '0;
	logic                          out_valid;
	logic                          out_stall   = 1'b0;
	logic [hsvrgb_pkg::LevelW-1:0] red_level;
	logic [hsvrgb_pkg::LevelW-1:0] green_level;
	logic [hsvrgb_pkg::LevelW-1:0] blue_level;

	// The pinned colour travels with a directed request that has a typed-in result.
	bit   pinned     = 1'b0;
	rgb_t pinned_rgb = '0;

	rgb_t        awaited_rgb[$];
	colour_row_t colour_table[$];
	rgb_t        got_rgb;
	rgb_t        want_rgb;
	int          errors        = 0;
	int          requests_in   = 0;
	int          results_out   = 0;
	int          clamped_hues  = 0;
	int          stalled_cycles = 0;
	int          idle_cycles   = 0;
	int          burst_left    = 0;
	int unsigned stall_mode    = 0;
	int unsigned stall_span    = 0;
	int unsigned stall_phase   = 0;

	hsv_to_rgb_converter dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.hue_deg     (hue_deg),
		.sat_pct     (sat_pct),
		.val_pct     (val_pct),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.red_level   (red_level),
		.green_level (green_level),
		.blue_level  (blue_level)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic rgb_t hsv_colour(input logic [hsvrgb_pkg::HueW-1:0] hue,
			input logic [hsvrgb_pkg::PctW-1:0] sat,
			input logic [hsvrgb_pkg::PctW-1:0] val);
		int unsigned         h, s, v, rem, span_dist, peak, floor_lvl, mid_lvl;
		hsvrgb_pkg::sector_t sec;
		rgb_t                c;
		h = (hue >= hsvrgb_pkg::HueFull) ? 0 : hue;
		s = (sat > hsvrgb_pkg::PctFull) ? hsvrgb_pkg::PctFull : sat;
		v = (val > hsvrgb_pkg::PctFull) ? hsvrgb_pkg::PctFull : val;
		rem = h % 120;
		span_dist = (rem >= 60) ? rem - 60 : 60 - rem;
		peak = (255 * v) / 100;
		floor_lvl = (255 * v * (100 - s)) / 10000;
		mid_lvl = (255 * v * (6000 - s * span_dist)) / 600000;
		if (h < hsvrgb_pkg::Hue60)
			sec = hsvrgb_pkg::SecRed;
		else if (h < hsvrgb_pkg::Hue120)
			sec = hsvrgb_pkg::SecYellow;
		else if (h < hsvrgb_pkg::Hue180)
			sec = hsvrgb_pkg::SecGreen;
		else if (h < hsvrgb_pkg::Hue240)
			sec = hsvrgb_pkg::SecCyan;
		else if (h < hsvrgb_pkg::Hue300)
			sec = hsvrgb_pkg::SecBlue;
		else
			sec = hsvrgb_pkg::SecMagenta;
		case (sec)
			hsvrgb_pkg::SecRed: begin
				c.red = peak[hsvrgb_pkg::LevelW-1:0];
				c.green = mid_lvl[hsvrgb_pkg::LevelW-1:0];
				c.blue = floor_lvl[hsvrgb_pkg::LevelW-1:0];
			end
			hsvrgb_pkg::SecYellow: begin
				c.red = mid_lvl[hsvrgb_pkg::LevelW-1:0];
				c.green = peak[hsvrgb_pkg::LevelW-1:0];
				c.blue = floor_lvl[hsvrgb_pkg::LevelW-1:0];
			end
			hsvrgb_pkg::SecGreen: begin
				c.red = floor_lvl[hsvrgb_pkg::LevelW-1:0];
				c.green = peak[hsvrgb_pkg::LevelW-1:0];
				c.blue = mid_lvl[hsvrgb_pkg::LevelW-1:0];
			end
			hsvrgb_pkg::SecCyan: begin
				c.red = floor_lvl[hsvrgb_pkg::LevelW-1:0];
				c.green = mid_lvl[hsvrgb_pkg::LevelW-1:0];
				c.blue = peak[hsvrgb_pkg::LevelW-1:0];
			end
			hsvrgb_pkg::SecBlue: begin
				c.red = mid_lvl[hsvrgb_pkg::LevelW-1:0];
				c.green = floor_lvl[hsvrgb_pkg::LevelW-1:0];
				c.blue = peak[hsvrgb_pkg::LevelW-1:0];
			end
			default: begin
				c.red = peak[hsvrgb_pkg::LevelW-1:0];
				c.green = floor_lvl[hsvrgb_pkg::LevelW-1:0];
				c.blue = mid_lvl[hsvrgb_pkg::LevelW-1:0];
			end
		endcase
		return c;
	endfunction

	task automatic add_row(input int h, input int s, input int v, input bit pin,
			input int r, input int g, input int b);
		colour_row_t row;
		row.hue = hsvrgb_pkg::HueW'(h);
		row.sat = hsvrgb_pkg::PctW'(s);
		row.val = hsvrgb_pkg::PctW'(v);
		row.pinned = pin;
		row.rgb.red = hsvrgb_pkg::LevelW'(r);
		row.rgb.green = hsvrgb_pkg::LevelW'(g);
		row.rgb.blue = hsvrgb_pkg::LevelW'(b);
		colour_table.push_back(row);
	endtask

	// Bursts of requests separated by gaps of random length; noise on the bus in gaps.
	task automatic send_colour(input colour_row_t row);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 4);
			repeat (gap) begin
				in_valid <= 1'b0;
				pinned   <= 1'b0;
				hue_deg  <= hsvrgb_pkg::HueW'($urandom);
				sat_pct  <= hsvrgb_pkg::PctW'($urandom);
				val_pct  <= hsvrgb_pkg::PctW'($urandom);
				@(posedge clk);
			end
			burst_left = $urandom_range(1, 48);
		end
		burst_left--;
		in_valid   <= 1'b1;
		hue_deg    <= row.hue;
		sat_pct    <= row.sat;
		val_pct    <= row.val;
		pinned     <= row.pinned;
		pinned_rgb <= row.rgb;
		do
			@(posedge clk);
		while (in_stall);
	endtask

	// The receiver switches between no stalls, light and heavy random stalls
	// and a regular stall pattern.
	always @(posedge clk) begin
		if (stall_span == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_span <= $urandom_range(50, 300);
		end else begin
			stall_span <= stall_span - 1;
		end
		stall_phase <= stall_phase + 1;
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 99) < 30);
			2: out_stall <= ($urandom_range(0, 99) < 75);
			default: out_stall <= (stall_phase % 4 != 0);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (out_valid && out_stall)
				stalled_cycles++;
			if (in_valid && !in_stall) begin
				awaited_rgb.push_back(pinned ? pinned_rgb
						: hsv_colour(hue_deg, sat_pct, val_pct));
				requests_in++;
				if (hue_deg >= hsvrgb_pkg::HueFull)
					clamped_hues++;
			end
			if (out_valid && !out_stall) begin
				results_out++;
				got_rgb.red = red_level;
				got_rgb.green = green_level;
				got_rgb.blue = blue_level;
				if (awaited_rgb.size() == 0) begin
					$error("Result %0d arrived with no request outstanding.", results_out);
					errors++;
				end else begin
					want_rgb = awaited_rgb.pop_front();
					if (got_rgb.red !== want_rgb.red) begin
						$error("red_level: expected %0d, got %0d", want_rgb.red, got_rgb.red);
						errors++;
					end
					if (got_rgb.green !== want_rgb.green) begin
						$error("green_level: expected %0d, got %0d",
								want_rgb.green, got_rgb.green);
						errors++;
					end
					if (got_rgb.blue !== want_rgb.blue) begin
						$error("blue_level: expected %0d, got %0d",
								want_rgb.blue, got_rgb.blue);
						errors++;
					end
				end
			end
		end
	end

	initial begin
		while (idle_cycles < IdleLimit)
			@(posedge clk);
		$display("Timeout: no request moved for %0d cycles.", IdleLimit);
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		colour_row_t row;
		int          pick;
		// Results that can be read off directly.
		add_row(0,   0,   0,   1, 0,   0,   0);
		add_row(0,   100, 100, 1, 255, 0,   0);
		add_row(120, 100, 100, 1, 0,   255, 0);
		add_row(240, 100, 100, 1, 0,   0,   255);
		add_row(60,  100, 100, 1, 255, 255, 0);
		add_row(180, 100, 100, 1, 0,   255, 255);
		add_row(300, 100, 100, 1, 255, 0,   255);
		add_row(360, 100, 100, 1, 255, 0,   0);
		add_row(511, 127, 127, 1, 255, 0,   0);
		add_row(200, 0,   100, 1, 255, 255, 255);
		add_row(90,  127, 0,   1, 0,   0,   0);
		// Sector edges, clamping and mixed levels, checked against the prediction.
		add_row(59,  100, 100, 0, 0, 0, 0);
		add_row(61,  37,  88,  0, 0, 0, 0);
		add_row(119, 50,  50,  0, 0, 0, 0);
		add_row(121, 100, 100, 0, 0, 0, 0);
		add_row(179, 1,   99,  0, 0, 0, 0);
		add_row(181, 100, 1,   0, 0, 0, 0);
		add_row(239, 75,  75,  0, 0, 0, 0);
		add_row(241, 20,  100, 0, 0, 0, 0);
		add_row(299, 100, 100, 0, 0, 0, 0);
		add_row(301, 64,  64,  0, 0, 0, 0);
		add_row(359, 100, 100, 0, 0, 0, 0);
		add_row(361, 50,  50,  0, 0, 0, 0);
		add_row(100, 101, 100, 0, 0, 0, 0);
		add_row(30,  100, 101, 0, 0, 0, 0);
		add_row(256, 64,  127, 0, 0, 0, 0);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (colour_table[i])
			send_colour(colour_table[i]);

		for (int n = 0; n < RandomColours; n++) begin
			pick = $urandom_range(0, 9);
			if (pick < 7)
				row.hue = hsvrgb_pkg::HueW'($urandom_range(0, 359));
			else if (pick == 7)
				row.hue = hsvrgb_pkg::HueW'(60 * $urandom_range(0, 6)
						+ $urandom_range(0, 2) - 1);
			else
				row.hue = hsvrgb_pkg::HueW'($urandom);
			row.sat = ($urandom_range(0, 4) == 0) ? hsvrgb_pkg::PctW'($urandom)
					: hsvrgb_pkg::PctW'($urandom_range(0, 100));
			row.val = ($urandom_range(0, 4) == 0) ? hsvrgb_pkg::PctW'($urandom)
					: hsvrgb_pkg::PctW'($urandom_range(0, 100));
			row.pinned = 1'b0;
			row.rgb = '0;
			send_colour(row);
		end
		in_valid <= 1'b0;
		pinned   <= 1'b0;

		while (awaited_rgb.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);

		$display("Checked %0d colour conversions, %0d of them from the directed table.",
				results_out, colour_table.size());
		$display("Requests with clamped hue: %0d; cycles with a result held by stall: %0d.",
				clamped_hues, stalled_cycles);
		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0d mismatches found.", errors);
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
